@@ design/tc_pkg.sv @@
// Shared constants and types for the tetrahedron circumcenter block.
`default_nettype none
package tc_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int OUT_BITS       = 32;
  localparam int NUM_VERT       = 4;
  localparam int NUM_AXES       = 3;

  typedef struct packed {
    logic saturated;
    logic degenerate;
  } tc_flags_t;
endpackage
`default_nettype wire

@@ design/tetrahedron_circumcenter.sv @@
// Pipelined tetrahedron circumcenter: exact determinants and restoring division.
//
//  channel  | ports           | contents
//  ---------+-----------------+---------------------------------------------
//  in       | in_tvalid/ready | in_tdata: p0_x p0_y p0_z .. p3_x p3_y p3_z
//  out      | out_tvalid/ready| out_tdata: center_x/y/z; out_tuser: flags
//
// One tetrahedron per cycle while the skid register is empty. From the input
// transfer, data passes stages 1 to 7, stage 8, the quotient stages, the result
// register and the output register; 32 of the stages are the radix-2 quotient stages.
// rst_n (synchronous) clears all valid bits, the output and skid valid flags included.
// out_tready low lets the pipe run until the skid register fills; in_tready
// drops as soon as it does. Nothing is dropped or repeated.
`default_nettype none
module tetrahedron_circumcenter #(
  parameter int COORD_BITS = tc_pkg::COORD_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output      logic                                    in_tready,
  // p0_x, p0_y, p0_z, p1_x, .. p3_z, COORD_BITS each, zero fill to bytes
  input  wire logic [((12*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  output      logic                                    out_tvalid,
  input  wire logic                                    out_tready,
  // center_x, center_y, center_z, 32 bits each
  output      logic [3*tc_pkg::OUT_BITS-1:0]           out_tdata,
  // degenerate, saturated
  output      logic [1:0]                              out_tuser
);
  import tc_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int QB   = OUT_BITS;
  localparam int DW   = CB + 1;
  localparam int EW   = 2*CB + 2;
  localparam int PW   = 2*DW;
  localparam int MW   = 2*DW + 1;
  localparam int H    = DW;
  localparam int EHW  = EW - H;
  localparam int TW   = EW + MW;
  localparam int NW   = TW + 2;
  localparam int AW   = DW + MW + 2;
  localparam int DENW = AW + 1;
  localparam int CW   = (NW > DENW + QB) ? NW : DENW + QB;
  localparam int NP   = 9 + QB;

  localparam int RA [3] = '{1, 0, 0};
  localparam int RB [3] = '{2, 2, 1};

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QB-1:0]   nlo;
    logic [QB-1:0]   q;
    logic            ovf;
    logic            neg;
  } dch_t;

  typedef struct packed {
    dch_t [2:0]      ch;
    logic [DENW-1:0] den;
    logic            deg;
  } dst_t;

  logic          ce;
  logic          sv_r;
  logic [NP:1]   vld_r;

  assign ce        = !sv_r;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NP-1:1], in_tvalid};
    end
  end

  // stage 1: edge vectors and squares
  logic signed [CB-1:0]   pt [4][3];
  logic signed [DW-1:0]   s1_d_r  [3][3];
  logic signed [2*CB-1:0] s1_sq_r [4][3];

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        pt[i][k] = $signed(in_tdata[(3*i+k)*CB +: CB]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 3; k++)
          s1_sq_r[i][k] <= pt[i][k] * pt[i][k];
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          s1_d_r[i][k] <= DW'(pt[i+1][k]) - DW'(pt[0][k]);
    end
  end

  // stage 2: squared-radius differences, 2x2 minor products
  logic signed [EW-1:0] r2 [4];
  logic signed [EW-1:0] s2_e_r  [3];
  logic signed [DW-1:0] s2_u_r  [3];
  logic signed [PW-1:0] s2_pa_r [3][3];
  logic signed [PW-1:0] s2_pb_r [3][3];

  always_comb begin
    for (int i = 0; i < 4; i++)
      r2[i] = EW'(s1_sq_r[i][0]) + EW'(s1_sq_r[i][1]) + EW'(s1_sq_r[i][2]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        s2_e_r[r] <= r2[r+1] - r2[0];
        s2_u_r[r] <= s1_d_r[r][0];
      end
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++) begin
          s2_pa_r[p][r] <= s1_d_r[RA[r]][RA[p]] * s1_d_r[RB[r]][RB[p]];
          s2_pb_r[p][r] <= s1_d_r[RB[r]][RA[p]] * s1_d_r[RA[r]][RB[p]];
        end
    end
  end

  // stage 3: minors
  logic signed [MW-1:0] s3_m_r [3][3];
  logic signed [EW-1:0] s3_e_r [3];
  logic signed [DW-1:0] s3_u_r [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        s3_e_r[r] <= s2_e_r[r];
        s3_u_r[r] <= s2_u_r[r];
      end
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++)
          s3_m_r[p][r] <= MW'(s2_pa_r[p][r]) - MW'(s2_pb_r[p][r]);
    end
  end

  // stage 4: cofactor products, wide column split in two halves
  logic signed [DW+MW-1:0]    s4_ap_r [3];
  logic signed [EHW+MW-1:0]   s4_hi_r [3][3];
  logic signed [H+1+MW-1:0]   s4_lo_r [3][3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++)
        s4_ap_r[r] <= s3_u_r[r] * s3_m_r[0][r];
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++) begin
          s4_hi_r[p][r] <= $signed(s3_e_r[r][EW-1:H]) * s3_m_r[p][r];
          s4_lo_r[p][r] <= $signed({1'b0, s3_e_r[r][H-1:0]}) * s3_m_r[p][r];
        end
    end
  end

  // stage 5: merge halves, volume determinant
  logic signed [TW-1:0] s5_t_r [3][3];
  logic signed [AW-1:0] s5_a_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++)
          s5_t_r[p][r] <= (TW'(s4_hi_r[p][r]) <<< H) + TW'(s4_lo_r[p][r]);
      s5_a_r <= -(AW'(s4_ap_r[0]) - AW'(s4_ap_r[1]) + AW'(s4_ap_r[2]));
    end
  end

  // stage 6: numerators and denominator
  logic signed [NW-1:0]   det3 [3];
  logic signed [NW-1:0]   s6_num_r [3];
  logic signed [DENW-1:0] s6_den_r;
  logic                   s6_deg_r;

  always_comb begin
    for (int p = 0; p < 3; p++)
      det3[p] = NW'(s5_t_r[p][0]) - NW'(s5_t_r[p][1]) + NW'(s5_t_r[p][2]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s6_num_r[0] <= -det3[0];
      s6_num_r[1] <= det3[1];
      s6_num_r[2] <= -det3[2];
      s6_den_r    <= DENW'(s5_a_r) + DENW'(s5_a_r);
      s6_deg_r    <= (s5_a_r == '0);
    end
  end

  // stage 7: magnitudes and quotient signs
  logic [NW-1:0]   s7_nm_r [3];
  logic [DENW-1:0] s7_dm_r;
  logic [2:0]      s7_neg_r;
  logic            s7_deg_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        s7_nm_r[c]  <= s6_num_r[c][NW-1] ? NW'(-s6_num_r[c]) : NW'(s6_num_r[c]);
        s7_neg_r[c] <= s6_num_r[c][NW-1] ^ s6_den_r[DENW-1];
      end
      s7_dm_r  <= s6_den_r[DENW-1] ? DENW'(-s6_den_r) : DENW'(s6_den_r);
      s7_deg_r <= s6_deg_r;
    end
  end

  // stage 8 and quotient stages
  dst_t dv_r   [QB+1];
  dst_t dv_nxt [QB+1];
  logic [DENW:0] rs [QB][3];
  logic          ge [QB][3];

  always_comb begin
    dv_nxt[0].den = s7_dm_r;
    dv_nxt[0].deg = s7_deg_r;
    for (int c = 0; c < 3; c++) begin
      dv_nxt[0].ch[c].ovf = CW'(s7_nm_r[c]) >= (CW'(s7_dm_r) << QB);
      dv_nxt[0].ch[c].rem = DENW'(s7_nm_r[c] >> QB);
      dv_nxt[0].ch[c].nlo = s7_nm_r[c][QB-1:0];
      dv_nxt[0].ch[c].q   = '0;
      dv_nxt[0].ch[c].neg = s7_neg_r[c];
    end
    for (int j = 0; j < QB; j++) begin
      dv_nxt[j+1] = dv_r[j];
      for (int c = 0; c < 3; c++) begin
        rs[j][c] = {dv_r[j].ch[c].rem, dv_r[j].ch[c].nlo[QB-1-j]};
        ge[j][c] = rs[j][c] >= {1'b0, dv_r[j].den};
        dv_nxt[j+1].ch[c].rem = ge[j][c] ? DENW'(rs[j][c] - {1'b0, dv_r[j].den})
                                         : DENW'(rs[j][c]);
        dv_nxt[j+1].ch[c].q[QB-1-j] = ge[j][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j <= QB; j++)
        dv_r[j] <= dv_nxt[j];
    end
  end

  // result stage: clip, sign, degenerate case
  logic [QB-1:0]   lim   [3];
  logic [QB-1:0]   qs    [3];
  logic [2:0]      csat;
  logic [3*QB-1:0] res_nxt;
  tc_flags_t       flg_nxt;
  logic [3*QB-1:0] res_r;
  tc_flags_t       flg_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lim[c]  = dv_r[QB].ch[c].neg ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
      csat[c] = dv_r[QB].ch[c].ovf || (dv_r[QB].ch[c].q > lim[c]);
      qs[c]   = csat[c] ? lim[c] : dv_r[QB].ch[c].q;
      res_nxt[c*QB +: QB] = dv_r[QB].deg ? '0
                          : (dv_r[QB].ch[c].neg ? QB'(-qs[c]) : qs[c]);
    end
    flg_nxt.degenerate = dv_r[QB].deg;
    flg_nxt.saturated  = !dv_r[QB].deg && (|csat);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r <= res_nxt;
      flg_r <= flg_nxt;
    end
  end

  // output register with skid
  logic            ov_r;
  logic [3*QB-1:0] od_r;
  logic [3*QB-1:0] sd_r;
  tc_flags_t       of_r;
  tc_flags_t       sf_r;
  logic            take;
  logic            arrive;

  assign take   = ov_r && out_tready;
  assign arrive = vld_r[NP] && ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (take) begin
        sv_r <= 1'b0;
      end
    end else if (arrive) begin
      if (!ov_r || take) begin
        ov_r <= 1'b1;
      end else begin
        sv_r <= 1'b1;
      end
    end else if (take) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (take) begin
        od_r <= sd_r;
        of_r <= sf_r;
      end
    end else if (arrive) begin
      if (!ov_r || take) begin
        od_r <= res_r;
        of_r <= flg_r;
      end else begin
        sd_r <= res_r;
        sf_r <= flg_r;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = of_r;
endmodule
`default_nettype wire

@@ design/tc_chk.sv @@
// Port-level checker for the tetrahedron circumcenter, bound to the top level.
`default_nettype none
module tc_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [3*tc_pkg::OUT_BITS-1:0] out_tdata,
  input wire logic [1:0]                    out_tuser
);
  import tc_pkg::*;

  localparam logic [OUT_BITS-1:0] MAXV = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] MINV = {1'b1, {(OUT_BITS-1){1'b0}}};

  tc_flags_t fl;
  assign fl = out_tuser;

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output transfer changed");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fl.degenerate |-> out_tdata == '0 && !fl.saturated)
    else $error("degenerate result not zero");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fl.saturated |->
      out_tdata[0 +: OUT_BITS] == MAXV || out_tdata[0 +: OUT_BITS] == MINV ||
      out_tdata[OUT_BITS +: OUT_BITS] == MAXV || out_tdata[OUT_BITS +: OUT_BITS] == MINV ||
      out_tdata[2*OUT_BITS +: OUT_BITS] == MAXV ||
      out_tdata[2*OUT_BITS +: OUT_BITS] == MINV)
    else $error("saturated flag without a clipped coordinate");
endmodule

bind tetrahedron_circumcenter tc_chk u_tc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ tb/sv/tb_tetrahedron_circumcenter.sv @@
// Testbench for the tetrahedron circumcenter block: stream stimulus, exact prediction, scoreboard.
`default_nettype none
module tb_tetrahedron_circumcenter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = tc_pkg::COORD_BITS_DEF;
  localparam int OB = tc_pkg::OUT_BITS;
  localparam int IN_W = ((12 * CB + 7) / 8) * 8;
  localparam int LATENCY = 45;
  localparam longint MAX_CYCLES = 2000000;

  typedef struct packed {
    logic [OB-1:0] cz;
    logic [OB-1:0] cy;
    logic [OB-1:0] cx;
    logic          sat;
    logic          degen;
  } center_t;

  logic clk, rst_n;
  logic in_tvalid, out_tready;
  logic in_tready, out_tvalid;
  logic [IN_W-1:0] in_tdata;
  logic [3*OB-1:0] out_tdata;
  logic [1:0] out_tuser;

  center_t centers_q[$];
  int errors = 0, n_sent = 0, n_got = 0, n_degen = 0, n_sat = 0;
  longint cycles = 0;
  bit stall_en = 1;

  tetrahedron_circumcenter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout at %0t", $realtime);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Exact signed 200-bit arithmetic; products of three differences plus r2 fit easily.
  function automatic logic signed [199:0] det3(logic signed [199:0] c0[3],
      logic signed [199:0] c1[3], logic signed [199:0] c2[3]);
    logic signed [199:0] m0, m1, m2;
    m0 = c1[1] * c2[2] - c1[2] * c2[1];
    m1 = c1[0] * c2[2] - c1[2] * c2[0];
    m2 = c1[0] * c2[1] - c1[1] * c2[0];
    return c0[0] * m0 - c0[1] * m1 + c0[2] * m2;
  endfunction

  function automatic logic [OB-1:0] div_sat(logic signed [199:0] num,
      logic signed [199:0] den, inout logic sat);
    logic signed [199:0] q;
    q = num / den;
    if (q > 200'sd2147483647) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (q < -200'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return q[OB-1:0];
  endfunction

  function automatic center_t predict_center(logic [IN_W-1:0] d);
    logic signed [199:0] p[4][3];
    logic signed [199:0] r2[4], e[3], u[3], v[3], w[3];
    logic signed [199:0] a, dx, dy, dz;
    logic signed [CB-1:0] c;
    center_t res;
    logic sat;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) begin
        c = d[(3 * i + k) * CB +: CB];
        p[i][k] = c;
      end
    for (int i = 0; i < 4; i++)
      r2[i] = p[i][0] * p[i][0] + p[i][1] * p[i][1] + p[i][2] * p[i][2];
    for (int i = 0; i < 3; i++) begin
      e[i] = r2[i + 1] - r2[0];
      u[i] = p[i + 1][0] - p[0][0];
      v[i] = p[i + 1][1] - p[0][1];
      w[i] = p[i + 1][2] - p[0][2];
    end
    a = -det3(u, v, w);
    dx = -det3(e, v, w);
    dy = -det3(e, u, w);
    dz = -det3(e, u, v);
    res = '0;
    if (a == 0) begin
      res.degen = 1;
      return res;
    end
    sat = 0;
    res.cx = div_sat(dx, 2 * a, sat);
    res.cy = div_sat(-dy, 2 * a, sat);
    res.cz = div_sat(dz, 2 * a, sat);
    res.sat = sat;
    return res;
  endfunction

  // in_tvalid stays high after a transfer until the next gap or an idle point
  task automatic send_tetra(logic [CB-1:0] c[12]);
    logic [IN_W-1:0] d;
    center_t exp_c;
    int g;
    d = '0;
    for (int i = 0; i < 12; i++) d[i * CB +: CB] = c[i];
    g = stall_en ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    exp_c = predict_center(d);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    centers_q.push_back(exp_c);
    n_sent++;
  endtask

  // Result checker
  always @(posedge clk) begin
    center_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cx = out_tdata[0 +: OB];
      got.cy = out_tdata[OB +: OB];
      got.cz = out_tdata[2 * OB +: OB];
      got.degen = out_tuser[0];
      got.sat = out_tuser[1];
      n_got++;
      if (centers_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $realtime, got);
        errors++;
      end else begin
        want = centers_q.pop_front();
        if (got.degen) n_degen++;
        if (got.sat) n_sat++;
        if (got.cx !== want.cx)
          $display("%0t: center_x expected %h actual %h", $realtime, want.cx, got.cx);
        if (got.cy !== want.cy)
          $display("%0t: center_y expected %h actual %h", $realtime, want.cy, got.cy);
        if (got.cz !== want.cz)
          $display("%0t: center_z expected %h actual %h", $realtime, want.cz, got.cz);
        if (got.degen !== want.degen)
          $display("%0t: degenerate expected %b actual %b", $realtime, want.degen, got.degen);
        if (got.sat !== want.sat)
          $display("%0t: saturated expected %b actual %b", $realtime, want.sat, got.sat);
        if (got !== want) errors++;
      end
    end
  end

  // Receiver back-pressure
  initial begin
    int g;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (!stall_en) out_tready <= 1;
      else begin
        g = gap_len();
        out_tready <= (g == 0);
        if (g > 0) begin
          repeat (g - 1) @(posedge clk);
          out_tready <= 1;
        end
      end
    end
  end

  function automatic logic [CB-1:0] rnd_coord(int mode);
    logic [CB-1:0] c;
    case (mode)
      0: c = CB'($urandom);
      1: c = CB'($urandom_range(0, 8191) - 4096);
      2: c = $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: c = CB'($urandom_range(0, 15) - 8);
    endcase
    return c;
  endfunction

  task automatic test_directed();
    logic [CB-1:0] c[12];
    logic [CB-1:0] one;
    one = CB'(1 << 12);
    // unit tetrahedron
    c = '{0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one};
    send_tetra(c);
    // all vertices at the same point
    foreach (c[i]) c[i] = 24'h123456;
    send_tetra(c);
    // coplanar points
    c = '{0, 0, 0, one, 0, 0, 0, one, 0, one, one, 0};
    send_tetra(c);
    // collinear points
    c = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3};
    send_tetra(c);
    // flat tetrahedron spanning the full x and y range, one unit high
    c = '{24'h7fffff, 24'h7fffff, 0, 24'h800000, 24'h7fffff, 0,
          24'h7fffff, 24'h800000, 0, 24'h7fffff, 24'h7fffff, 1};
    send_tetra(c);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff};
    send_tetra(c);
    c = '{0, 0, 0, 24'h800000, 0, 0, 0, 24'h800000, 0, 0, 0, 24'h800000};
    send_tetra(c);
    c = '{24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
          24'h800000, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 24'h7fffff};
    send_tetra(c);
    c = '{24'hffffff, 24'hffffff, 24'hffffff, 0, 24'hffffff, 24'hffffff,
          24'hffffff, 0, 24'hffffff, 24'hffffff, 24'hffffff, 0};
    send_tetra(c);
    for (int k = 0; k < 12; k++) begin
      foreach (c[i]) c[i] = rnd_coord(3);
      c[k] = (k % 2) ? 24'h7fffff : 24'h800000;
      send_tetra(c);
    end
  endtask

  task automatic test_random(int n);
    logic [CB-1:0] c[12];
    int mode;
    for (int t = 0; t < n; t++) begin
      mode = $urandom_range(0, 3);
      foreach (c[i]) c[i] = rnd_coord(mode);
      if ($urandom_range(0, 19) == 0) begin
        // force a degenerate case: p3 = p2 + (p1 - p0)
        for (int k = 0; k < 3; k++) c[9 + k] = c[6 + k] + c[3 + k] - c[k];
      end
      send_tetra(c);
    end
  endtask

  task automatic test_drain_pause();
    in_tvalid <= 0;
    while (centers_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_full_rate(int n);
    stall_en = 0;
    test_random(n);
    stall_en = 1;
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    test_directed();
    test_random(700);
    test_drain_pause();
    test_full_rate(300);
    test_random(720);
    in_tvalid <= 0;
    while (centers_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    $display("Covered %0d tetrahedra, %0d results (%0d degenerate, %0d saturated),",
             n_sent, n_got, n_degen, n_sat);
    $display("with random stalls on both sides and one full-rate burst.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ tetrahedron_circumcenter.f @@
design/tc_pkg.sv
design/tetrahedron_circumcenter.sv
design/tc_chk.sv
tb/sv/tb_tetrahedron_circumcenter.sv
